// ----- hdl/lcd_mode_timing_controller_core_defines.svh -----
// ----------------------------------------------------------------------------
// LCD mode timing controller: assertion macros
// Shared concurrent-check macros. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_CONTROLLER_CORE_DEFINES_SVH
`define LCD_MODE_TIMING_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge of clk out of reset
`define LCDT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdt check failed");

// Next-cycle implication
`define LCDT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdt check failed");

`else

`define LCDT_ASSERT_IMPL(name, ante, cons)
`define LCDT_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- hdl/lcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller package
// Types, timing constants and register codes shared by all modules.
// ----------------------------------------------------------------------------
package lcdt_pkg;

    // Display geometry
    localparam logic [9:0] DOTS_PER_LINE   = 10'd456;
    localparam logic [7:0] LINES_PER_FRAME = 8'd154;
    localparam logic [7:0] VISIBLE_LINES   = 8'd144;

    // Time advances in chunks of this many dots
    localparam logic [6:0] CHUNK_DOTS = 7'd80;

    // Mode boundaries within a line
    localparam logic [8:0] SEARCH_END = 9'd80;
    localparam logic [8:0] DRAW_END   = 9'd252;

    // Status register masks and reset values
    localparam logic [7:0] STAT_WRITABLE = 8'h78;
    localparam logic [7:0] STAT_KEPT     = 8'h87;
    localparam logic [7:0] CONTROL_RESET = 8'h91;

    // Status register bit positions
    localparam int STAT_COIN_EN   = 6;
    localparam int STAT_SEARCH_EN = 5;
    localparam int STAT_VBLANK_EN = 4;
    localparam int STAT_HBLANK_EN = 3;
    localparam int STAT_COIN      = 2;

    // Register offsets
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_STATUS  = 3'd1;
    localparam logic [2:0] REG_LINE    = 3'd4;
    localparam logic [2:0] REG_COMPARE = 3'd5;

    // Status modes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // Acknowledge kinds
    localparam logic ACK_STAT   = 1'b0;
    localparam logic ACK_VBLANK = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_ACK   = 2'd3
    } lcdt_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_FINISH
    } lcdt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } lcdt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tick_start;
        logic last_chunk;
    } lcdt_stat_t;

endpackage

// ----- hdl/lcdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller: sequencer
// State machine that loads a transaction, steps the dot chunks and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`include "lcd_mode_timing_controller_core_defines.svh"

module lcdt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  lcdt_pkg::lcdt_stat_t stat,
    output lcdt_pkg::lcdt_cmd_t  cmd
);

    lcdt_pkg::lcdt_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            lcdt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.tick_start ? lcdt_pkg::ST_CHUNK : lcdt_pkg::ST_FINISH;
                end
            end
            lcdt_pkg::ST_CHUNK:
            begin
                cmd.step = 1'b1;
                if (stat.last_chunk)
                begin
                    state_next = lcdt_pkg::ST_FINISH;
                end
            end
            lcdt_pkg::ST_FINISH:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = lcdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `LCDT_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall,
        state_reg != lcdt_pkg::ST_IDLE)
    `LCDT_ASSERT_IMPL(a_finish_slot_free, cmd.finish, !(out_valid_reg && out_stall))
    `LCDT_ASSERT_NEXT(a_last_chunk_finishes,
        state_reg == lcdt_pkg::ST_CHUNK && stat.last_chunk,
        state_reg == lcdt_pkg::ST_FINISH)

endmodule

// ----- hdl/lcdt_dp.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller: datapath
// Dot and line counters, status/control/compare registers, interrupt flags,
// chunk arithmetic and the output register.
// ----------------------------------------------------------------------------
`include "lcd_mode_timing_controller_core_defines.svh"

module lcdt_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcdt_pkg::lcdt_cmd_t  cmd,
    output lcdt_pkg::lcdt_stat_t stat,
    input  logic [1:0]           mode,
    input  logic [9:0]           dots_elapsed,
    input  logic [2:0]           reg_offset,
    input  logic [7:0]           write_data,
    input  logic                 ack_kind,
    output logic [7:0]           read_data,
    output logic                 stat_irq_pending,
    output logic                 vblank_irq_pending,
    output logic [1:0]           lcd_mode,
    output logic [7:0]           scan_line
);

    // Latched transaction
    lcdt_pkg::lcdt_op_t kind_reg;
    logic [9:0]         rem_reg;
    logic [2:0]         off_reg;
    logic [7:0]         data_reg;
    logic               ack_reg;

    // Architectural state
    logic [8:0] dot_reg, dot_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] compare_reg, compare_next;
    logic       stat_pend_reg, stat_pend_next;
    logic       vblank_pend_reg, vblank_pend_next;

    // Output register
    logic [7:0] rd_out_reg;
    logic       stat_out_reg;
    logic       vblank_out_reg;
    logic [1:0] mode_out_reg;
    logic [7:0] line_out_reg;

    logic [6:0] chunk_add;
    logic [9:0] dot_sum;
    logic       wrap;
    logic [8:0] dot_wrapped;
    logic [7:0] line_inc;
    logic [7:0] rd_value;

    assign stat.tick_start = (lcdt_pkg::lcdt_op_t'(mode) == lcdt_pkg::OP_TICK)
                             && (dots_elapsed != 10'd0);
    assign stat.last_chunk = rem_reg < {3'd0, lcdt_pkg::CHUNK_DOTS};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= lcdt_pkg::lcdt_op_t'(mode);
            rem_reg  <= dots_elapsed;
            off_reg  <= reg_offset;
            data_reg <= write_data;
            ack_reg  <= ack_kind;
        end
        else if (cmd.step && !stat.last_chunk)
        begin
            rem_reg <= rem_reg - {3'd0, lcdt_pkg::CHUNK_DOTS};
        end
    end

    // Chunk arithmetic: full chunks of 80, then the remainder
    assign chunk_add   = stat.last_chunk ? rem_reg[6:0] : lcdt_pkg::CHUNK_DOTS;
    assign dot_sum     = {1'b0, dot_reg} + {3'd0, chunk_add};
    assign wrap        = dot_sum >= lcdt_pkg::DOTS_PER_LINE;
    assign dot_wrapped = wrap ? 9'(dot_sum - lcdt_pkg::DOTS_PER_LINE) : dot_sum[8:0];
    assign line_inc    = (line_reg == lcdt_pkg::LINES_PER_FRAME - 8'd1) ? 8'd0
                                                                        : line_reg + 8'd1;

    always_comb
    begin
        dot_next         = dot_reg;
        line_next        = line_reg;
        status_next      = status_reg;
        control_next     = control_reg;
        compare_next     = compare_reg;
        stat_pend_next   = stat_pend_reg;
        vblank_pend_next = vblank_pend_reg;
        rd_value         = 8'd0;

        if (cmd.step)
        begin
            dot_next = dot_wrapped;
            if (wrap)
            begin
                line_next = line_inc;
                status_next[lcdt_pkg::STAT_COIN] = (line_inc == compare_reg);
                if (status_next[lcdt_pkg::STAT_COIN_EN] && status_next[lcdt_pkg::STAT_COIN])
                begin
                    stat_pend_next = 1'b1;
                end
            end

            // Mode transitions on the updated position
            if (line_next >= lcdt_pkg::VISIBLE_LINES)
            begin
                if (status_next[1:0] != lcdt_pkg::MODE_VBLANK)
                begin
                    status_next[1:0] = lcdt_pkg::MODE_VBLANK;
                    if (status_next[lcdt_pkg::STAT_VBLANK_EN])
                    begin
                        stat_pend_next = 1'b1;
                    end
                    vblank_pend_next = 1'b1;
                end
            end
            else if (dot_next <= lcdt_pkg::SEARCH_END)
            begin
                if (status_next[1:0] != lcdt_pkg::MODE_SEARCH)
                begin
                    if (status_next[lcdt_pkg::STAT_SEARCH_EN])
                    begin
                        stat_pend_next = 1'b1;
                    end
                    status_next[1:0] = lcdt_pkg::MODE_SEARCH;
                end
            end
            else if (dot_next <= lcdt_pkg::DRAW_END)
            begin
                status_next[1:0] = lcdt_pkg::MODE_DRAW;
            end
            else if (status_next[1:0] != lcdt_pkg::MODE_HBLANK)
            begin
                if (status_next[lcdt_pkg::STAT_HBLANK_EN])
                begin
                    stat_pend_next = 1'b1;
                end
                status_next[1:0] = lcdt_pkg::MODE_HBLANK;
            end
        end

        if (cmd.finish)
        begin
            unique case (kind_reg)
                lcdt_pkg::OP_WRITE:
                begin
                    unique case (off_reg)
                        lcdt_pkg::REG_CONTROL: control_next = data_reg;
                        lcdt_pkg::REG_STATUS:
                            status_next = (data_reg & lcdt_pkg::STAT_WRITABLE)
                                        | (status_reg & lcdt_pkg::STAT_KEPT);
                        lcdt_pkg::REG_COMPARE: compare_next = data_reg;
                        default: ;
                    endcase
                end
                lcdt_pkg::OP_READ:
                begin
                    unique case (off_reg)
                        lcdt_pkg::REG_CONTROL: rd_value = control_reg;
                        lcdt_pkg::REG_STATUS:  rd_value = status_reg;
                        lcdt_pkg::REG_LINE:    rd_value = line_reg;
                        lcdt_pkg::REG_COMPARE: rd_value = compare_reg;
                        default:               rd_value = 8'd0;
                    endcase
                end
                lcdt_pkg::OP_ACK:
                begin
                    if (ack_reg == lcdt_pkg::ACK_STAT)
                    begin
                        stat_pend_next = 1'b0;
                    end
                    else
                    begin
                        vblank_pend_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg         <= 9'd0;
            line_reg        <= 8'd0;
            status_reg      <= 8'd0;
            control_reg     <= lcdt_pkg::CONTROL_RESET;
            compare_reg     <= 8'd0;
            stat_pend_reg   <= 1'b0;
            vblank_pend_reg <= 1'b0;
        end
        else
        begin
            dot_reg         <= dot_next;
            line_reg        <= line_next;
            status_reg      <= status_next;
            control_reg     <= control_next;
            compare_reg     <= compare_next;
            stat_pend_reg   <= stat_pend_next;
            vblank_pend_reg <= vblank_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rd_out_reg     <= rd_value;
            stat_out_reg   <= stat_pend_next;
            vblank_out_reg <= vblank_pend_next;
            mode_out_reg   <= status_next[1:0];
            line_out_reg   <= line_next;
        end
    end

    assign read_data          = rd_out_reg;
    assign stat_irq_pending   = stat_out_reg;
    assign vblank_irq_pending = vblank_out_reg;
    assign lcd_mode           = mode_out_reg;
    assign scan_line          = line_out_reg;

    `LCDT_ASSERT_IMPL(a_dot_in_line, 1'b1, {1'b0, dot_reg} < lcdt_pkg::DOTS_PER_LINE)
    `LCDT_ASSERT_IMPL(a_line_in_frame, 1'b1, line_reg < lcdt_pkg::LINES_PER_FRAME)
    `LCDT_ASSERT_NEXT(a_vblank_mode_flag,
        cmd.step && line_next >= lcdt_pkg::VISIBLE_LINES
        && status_reg[1:0] != lcdt_pkg::MODE_VBLANK,
        vblank_pend_reg && status_reg[1:0] == lcdt_pkg::MODE_VBLANK)

endmodule

// ----- hdl/lcd_mode_timing_controller_core.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller core
// Dot/line timing, status mode and interrupt flags, register bus access.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ----------------------------------------------
//  in       in_valid / in_stall  mode, dots_elapsed, reg_offset, write_data,
//                                ack_kind
//  out      out_valid/out_stall  read_data, stat_irq_pending, vblank_irq_pending,
//                                lcd_mode, scan_line
//
//  A tick transaction steps its dots through the shared chunk adder in full
//  80-dot chunks, then the remainder, and then finishes into the output
//  register. Register, read, acknowledge and zero-dot ticks go from accept
//  straight to the finish. No new transaction is accepted until the block
//  is back in idle.
//  Reset (rst_n low, asynchronous) returns counters, registers and flags to
//  their power-on values; control reads 0x91.
//  The output register holds a finished transaction while out_stall is high;
//  the next transaction is accepted meanwhile and waits in its finish state.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_core (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [9:0] dots_elapsed,
    input  logic [2:0] reg_offset,
    input  logic [7:0] write_data,
    input  logic       ack_kind,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       stat_irq_pending,
    output logic       vblank_irq_pending,
    output logic [1:0] lcd_mode,
    output logic [7:0] scan_line
);

    // command and status between sequencer and datapath
    lcdt_pkg::lcdt_cmd_t  cmd;
    lcdt_pkg::lcdt_stat_t stat;

    // Sequencer: accept, step chunks, finish into the output register
    lcdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: timing counters, registers, flags and result capture
    lcdt_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .mode               (mode),
        .dots_elapsed       (dots_elapsed),
        .reg_offset         (reg_offset),
        .write_data         (write_data),
        .ack_kind           (ack_kind),
        .read_data          (read_data),
        .stat_irq_pending   (stat_irq_pending),
        .vblank_irq_pending (vblank_irq_pending),
        .lcd_mode           (lcd_mode),
        .scan_line          (scan_line)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD mode timing controller testbench
// Drives tick, register and acknowledge transactions through the valid/stall
// input channel, predicts every status result in a scoreboard that mirrors
// the dot/line timing, and checks each result field by field while both
// channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb_top;
    import lcdt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 490;
    // Room for the longest tick and its return to idle, and for stalls
    localparam int DRAIN_CYCLES   = 32;
    localparam int TIMEOUT_CYCLES = 600000;

    // Offset that decodes to no register
    localparam logic [2:0] REG_UNUSED = 3'd6;

    // One result transaction, laid out in port order
    typedef struct packed {
        logic [7:0] read_data;
        logic       stat_irq;
        logic       vblank_irq;
        logic [1:0] lcd_mode;
        logic [7:0] scan_line;
    } lcd_status_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the timing state, works out the
    // status each accepted transaction leaves behind, and matches results
    // in order against those predictions.
    // ------------------------------------------------------------------------
    class lcd_timing_scoreboard;
        bit [8:0]    dot_pos;
        bit [7:0]    line_num;
        bit [7:0]    stat_reg;
        bit [7:0]    ctrl_reg;
        bit [7:0]    lyc_reg;
        bit          stat_flag;
        bit          vblank_flag;
        lcd_status_t expected_q[$];
        int unsigned mismatch_count;

        function new();
            dot_pos        = '0;
            line_num       = '0;
            stat_reg       = '0;
            ctrl_reg       = CONTROL_RESET;
            lyc_reg        = '0;
            stat_flag      = 1'b0;
            vblank_flag    = 1'b0;
            mismatch_count = 0;
        endfunction

        // Advance the dot position by one chunk and re-evaluate the mode
        function void apply_chunk(int unsigned add);
            int unsigned pos;
            pos = dot_pos + add;
            if (pos >= DOTS_PER_LINE)
            begin
                pos = pos - DOTS_PER_LINE;
                line_num = (line_num + 1 >= LINES_PER_FRAME) ? 8'd0 : line_num + 8'd1;
                stat_reg[STAT_COIN] = (line_num == lyc_reg);
                if (stat_reg[STAT_COIN_EN] && stat_reg[STAT_COIN])
                    stat_flag = 1'b1;
            end
            dot_pos = 9'(pos);

            if (line_num >= VISIBLE_LINES)
            begin
                if (stat_reg[1:0] != MODE_VBLANK)
                begin
                    stat_reg[1:0] = MODE_VBLANK;
                    if (stat_reg[STAT_VBLANK_EN])
                        stat_flag = 1'b1;
                    vblank_flag = 1'b1;
                end
            end
            else if (dot_pos <= SEARCH_END)
            begin
                if (stat_reg[1:0] != MODE_SEARCH)
                begin
                    if (stat_reg[STAT_SEARCH_EN])
                        stat_flag = 1'b1;
                    stat_reg[1:0] = MODE_SEARCH;
                end
            end
            else if (dot_pos <= DRAW_END)
            begin
                stat_reg[1:0] = MODE_DRAW;
            end
            else if (stat_reg[1:0] != MODE_HBLANK)
            begin
                if (stat_reg[STAT_HBLANK_EN])
                    stat_flag = 1'b1;
                stat_reg[1:0] = MODE_HBLANK;
            end
        endfunction

        function void note_transaction(lcdt_op_t op, logic [9:0] dots, logic [2:0] offset,
                                       logic [7:0] data, logic ack);
            lcd_status_t res;
            res = '0;
            case (op)
                OP_TICK:
                begin
                    // Full chunks first, then the remainder; a zero tick does nothing
                    repeat (dots / CHUNK_DOTS) apply_chunk(CHUNK_DOTS);
                    if (dots != 0)
                        apply_chunk(dots % CHUNK_DOTS);
                end
                OP_WRITE:
                begin
                    case (offset)
                        REG_CONTROL: ctrl_reg = data;
                        REG_STATUS:  stat_reg = (data & STAT_WRITABLE) | (stat_reg & STAT_KEPT);
                        REG_COMPARE: lyc_reg = data;
                        default: ;
                    endcase
                end
                OP_READ:
                begin
                    case (offset)
                        REG_CONTROL: res.read_data = ctrl_reg;
                        REG_STATUS:  res.read_data = stat_reg;
                        REG_LINE:    res.read_data = line_num;
                        REG_COMPARE: res.read_data = lyc_reg;
                        default: ;
                    endcase
                end
                OP_ACK:
                begin
                    if (ack == ACK_STAT)
                        stat_flag = 1'b0;
                    else
                        vblank_flag = 1'b0;
                end
                default: ;
            endcase
            res.stat_irq   = stat_flag;
            res.vblank_irq = vblank_flag;
            res.lcd_mode   = stat_reg[1:0];
            res.scan_line  = line_num;
            expected_q.push_back(res);
        endfunction

        function void check_result(lcd_status_t actual);
            lcd_status_t exp_res;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, actual);
                mismatch_count++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (actual.read_data != exp_res.read_data)
            begin
                $display("%0t: read_data expected %h, actual %h",
                         $time, exp_res.read_data, actual.read_data);
                mismatch_count++;
            end
            if (actual.stat_irq != exp_res.stat_irq)
            begin
                $display("%0t: stat_irq_pending expected %b, actual %b",
                         $time, exp_res.stat_irq, actual.stat_irq);
                mismatch_count++;
            end
            if (actual.vblank_irq != exp_res.vblank_irq)
            begin
                $display("%0t: vblank_irq_pending expected %b, actual %b",
                         $time, exp_res.vblank_irq, actual.vblank_irq);
                mismatch_count++;
            end
            if (actual.lcd_mode != exp_res.lcd_mode)
            begin
                $display("%0t: lcd_mode expected %0d, actual %0d",
                         $time, exp_res.lcd_mode, actual.lcd_mode);
                mismatch_count++;
            end
            if (actual.scan_line != exp_res.scan_line)
            begin
                $display("%0t: scan_line expected %0d, actual %0d",
                         $time, exp_res.scan_line, actual.scan_line);
                mismatch_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input starts at a known value
    // ------------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [1:0] mode         = '0;
    logic [9:0] dots_elapsed = '0;
    logic [2:0] reg_offset   = '0;
    logic [7:0] write_data   = '0;
    logic       ack_kind     = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] read_data;
    logic       stat_irq_pending;
    logic       vblank_irq_pending;
    logic [1:0] lcd_mode;
    logic [7:0] scan_line;

    // Percent chance per cycle that the sender idles / the receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;

    lcd_timing_scoreboard sb;

    lcd_mode_timing_controller_core uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .dots_elapsed       (dots_elapsed),
        .reg_offset         (reg_offset),
        .write_data         (write_data),
        .ack_kind           (ack_kind),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .read_data          (read_data),
        .stat_irq_pending   (stat_irq_pending),
        .vblank_irq_pending (vblank_irq_pending),
        .lcd_mode           (lcd_mode),
        .scan_line          (scan_line)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Receiver: redraw the stall every cycle at the current phase's rate
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Check every result transaction taken at this edge against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(lcd_status_t'({read_data, stat_irq_pending, vblank_irq_pending,
                                           lcd_mode, scan_line}));
    end

    // ------------------------------------------------------------------------
    // Drive one input transaction: idle at random first, then hold the
    // payload until the block takes it, and note it with the scoreboard
    // ------------------------------------------------------------------------
    task automatic send_item(lcdt_op_t op, logic [9:0] dots, logic [2:0] offset,
                             logic [7:0] data, logic ack);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= op;
        dots_elapsed <= dots;
        reg_offset   <= offset;
        write_data   <= data;
        ack_kind     <= ack;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transaction(op, dots, offset, data, ack);
    endtask

    // Random traffic: mostly ticks so that frames roll over several times,
    // with status enables and compare values stirred in between
    task automatic run_phase(int send_idle, int rcv_stall);
        int unsigned pick;
        logic [9:0]  dots;
        logic [2:0]  offset;
        logic [7:0]  data;
        logic        ack;
        idle_pct  = send_idle;
        stall_pct <= rcv_stall;
        repeat (PHASE_ITEMS)
        begin
            // Fill every field, used or not, so the ignored ones toggle too
            pick   = $urandom_range(99);
            dots   = 10'($urandom_range(1023));
            offset = 3'($urandom_range(7));
            data   = 8'($urandom_range(255));
            ack    = 1'($urandom_range(1));
            if (pick < 60)
            begin
                case ($urandom_range(9))
                    0: dots = '0;
                    1: dots = 10'd1023;
                    2: dots = 10'($urandom_range(79, 1));
                    3: dots = 10'(CHUNK_DOTS * $urandom_range(12, 1));
                    default: ;
                endcase
                send_item(OP_TICK, dots, offset, data, ack);
            end
            else if (pick < 74)
            begin
                // Aim most writes at the status enables and at reachable compare lines
                case ($urandom_range(9))
                    0, 1, 2, 3: offset = REG_STATUS;
                    4, 5, 6:
                    begin
                        offset = REG_COMPARE;
                        if ($urandom_range(9) != 0)
                            data = 8'($urandom_range(LINES_PER_FRAME - 1));
                    end
                    default: ;
                endcase
                send_item(OP_WRITE, dots, offset, data, ack);
            end
            else if (pick < 88)
            begin
                send_item(OP_READ, dots, offset, data, ack);
            end
            else
            begin
                send_item(OP_ACK, dots, offset, data, ack);
            end
        end
    endtask

    initial
    begin
        sb = new();

        // Hold reset, then release it on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: power-on values of every offset, unused ones included
        for (int k = 0; k < 8; k++)
            send_item(OP_READ, '0, 3'(k), '0, 1'b0);

        // Zero tick with all unused fields high
        send_item(OP_TICK, 10'd0, 3'h7, 8'hff, 1'b1);
        // Status write takes only the enable bits
        send_item(OP_WRITE, 10'h3ff, REG_STATUS, 8'hff, 1'b1);
        send_item(OP_READ, '0, REG_STATUS, '0, 1'b0);
        // Compare on line 1; takes effect at the next wrap only
        send_item(OP_WRITE, '0, REG_COMPARE, 8'd1, 1'b0);
        // Line is read-only, unused offsets swallow writes
        send_item(OP_WRITE, '0, REG_LINE, 8'hff, 1'b0);
        send_item(OP_WRITE, '0, REG_UNUSED, 8'haa, 1'b0);
        send_item(OP_WRITE, '0, REG_CONTROL, 8'h00, 1'b0);
        send_item(OP_WRITE, '0, REG_CONTROL, 8'hff, 1'b0);
        // Longest tick wraps through line 1, hitting the compare, into line 2
        send_item(OP_TICK, 10'd1023, '0, '0, 1'b0);
        send_item(OP_TICK, 10'd80, '0, '0, 1'b0);
        send_item(OP_TICK, 10'd79, '0, '0, 1'b0);
        send_item(OP_READ, '0, REG_LINE, '0, 1'b0);
        send_item(OP_READ, '0, REG_STATUS, '0, 1'b0);
        send_item(OP_ACK, '0, '0, '0, ACK_STAT);
        send_item(OP_ACK, '0, '0, '0, ACK_VBLANK);
        send_item(OP_WRITE, '0, REG_COMPARE, 8'hff, 1'b0);
        send_item(OP_WRITE, '0, REG_STATUS, 8'h00, 1'b0);
        send_item(OP_READ, '0, REG_COMPARE, '0, 1'b0);

        // Random phases: clean, sender idling, receiver stalling, both
        run_phase(0, 0);
        run_phase(48, 0);
        run_phase(0, 48);
        run_phase(12, 12);
        in_valid  <= 1'b0;
        stall_pct <= 0;

        // Drain outstanding results, then give the block time to misbehave
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule
